>>> hw/rtl/uart_trx_pkg.sv
// ----------------------------------------------------------------------------
// UART transceiver package
// Field widths, register reset value and parameter defaults shared by the
// channel interfaces and the transceiver.
// ----------------------------------------------------------------------------
package uart_trx_pkg;

  // Width of the bit period register.
  localparam int BIT_PERIOD_W = 16;

  // Reset value of the bit period: 1000000 / 9600 ticks of one microsecond.
  localparam logic [BIT_PERIOD_W-1:0] BIT_PERIOD_RESET = 16'd104;

  // Width of the byte fields on both channels.
  localparam int BYTE_W = 8;

  // Parameter defaults.
  localparam int FRAME_BITS_DEFAULT       = 10;
  localparam int TICK_COUNT_WIDTH_DEFAULT = 16;

  typedef logic [BYTE_W-1:0] byte_t;

endpackage

>>> hw/rtl/uart_trx_if.sv
// ----------------------------------------------------------------------------
// UART transceiver channel interfaces
// The tick channel carries one time tick of line and transmit request; the
// result channel carries the line levels and flags produced for that tick.
// ----------------------------------------------------------------------------
interface uart_trx_in_if;
  import uart_trx_pkg::*;

  logic  valid;
  logic  ready;
  logic  rx_line;
  logic  tx_request;
  byte_t tx_byte;

  modport source (output valid, output rx_line, output tx_request, output tx_byte,
                  input ready);
  modport sink (input valid, input rx_line, input tx_request, input tx_byte,
                output ready);
endinterface

interface uart_trx_out_if;
  import uart_trx_pkg::*;

  logic  valid;
  logic  ready;
  logic  tx_line;
  logic  tx_busy;
  logic  tx_accepted;
  logic  rx_valid;
  byte_t rx_byte;

  modport source (output valid, output tx_line, output tx_busy, output tx_accepted,
                  output rx_valid, output rx_byte, input ready);
  modport sink (input valid, input tx_line, input tx_busy, input tx_accepted,
                input rx_valid, input rx_byte, output ready);
endinterface

>>> hw/rtl/uart_8n1_tx_rx.sv
// ----------------------------------------------------------------------------
// UART 8N1 transceiver
// Result: the result for a tick request is in the output register in the cycle
// after the request is accepted.
// Throughput: one tick request per cycle; a request is taken whenever the
// output register is empty or its result leaves in the same cycle, so only a
// stalled result holds the input.
// Reset: transmitter idle with the line high, receiver waiting for a start
// edge, bit period 104 ticks, output register empty.
// ----------------------------------------------------------------------------
module uart_8n1_tx_rx #(
  parameter int FRAME_BITS       = uart_trx_pkg::FRAME_BITS_DEFAULT,
  parameter int TICK_COUNT_WIDTH = uart_trx_pkg::TICK_COUNT_WIDTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [uart_trx_pkg::BIT_PERIOD_W-1:0] cfg_wdata,
  uart_trx_in_if.sink                           item_in,
  uart_trx_out_if.source                        result_out
);
  import uart_trx_pkg::*;

  localparam int PAYLOAD_BITS = FRAME_BITS - 2;
  localparam int IDX_W        = $clog2(FRAME_BITS + 1);
  localparam int CW           = ((TICK_COUNT_WIDTH > BIT_PERIOD_W) ?
                                 TICK_COUNT_WIDTH : BIT_PERIOD_W) + 1;
  localparam int EXT_W        = PAYLOAD_BITS + BYTE_W;

  logic [BIT_PERIOD_W-1:0] bit_period;

  logic [FRAME_BITS-1:0]       tx_shift,      tx_shift_next;
  logic [IDX_W-1:0]            tx_bits_left,  tx_bits_left_next;
  logic [TICK_COUNT_WIDTH-1:0] tx_tick_count, tx_tick_count_next;
  logic                        rx_active,     rx_active_next;
  logic [FRAME_BITS-1:0]       rx_shift,      rx_shift_next;
  logic [IDX_W-1:0]            rx_bit_index,  rx_bit_index_next;
  logic [TICK_COUNT_WIDTH-1:0] rx_tick_count, rx_tick_count_next;

  logic        out_valid;
  logic        tx_line, tx_busy, tx_accepted, rx_valid;
  byte_t       rx_byte;
  logic        res_tx_line, res_tx_busy, res_tx_accepted, res_rx_valid;
  byte_t       res_rx_byte;

  logic [CW-1:0]           bp_ext, per_limit, per;
  logic [EXT_W-1:0]        tx_ext, rx_ext;
  logic [PAYLOAD_BITS-1:0] tx_data;
  logic                    accept;

  assign item_in.ready = !out_valid || result_out.ready;
  assign accept        = item_in.valid && item_in.ready;

  // Effective bit period: zero acts as one, and it never exceeds what the
  // tick counters can span.
  assign bp_ext    = CW'(bit_period);
  assign per_limit = CW'(1) << TICK_COUNT_WIDTH;
  always_comb begin
    if (bit_period == '0) begin
      per = CW'(1);
    end else if (bp_ext > per_limit) begin
      per = per_limit;
    end else begin
      per = bp_ext;
    end
  end

  assign tx_ext  = EXT_W'(item_in.tx_byte);
  assign tx_data = tx_ext[PAYLOAD_BITS-1:0];

  // Transmitter.
  always_comb begin
    tx_shift_next      = tx_shift;
    tx_bits_left_next  = tx_bits_left;
    tx_tick_count_next = tx_tick_count;
    res_tx_line        = 1'b1;
    res_tx_busy        = 1'b0;
    res_tx_accepted    = 1'b0;
    if (tx_bits_left == '0 && item_in.tx_request) begin
      tx_shift_next      = {1'b1, tx_data, 1'b0};
      tx_bits_left_next  = IDX_W'(FRAME_BITS);
      tx_tick_count_next = '0;
      res_tx_accepted    = 1'b1;
    end
    if (tx_bits_left_next != '0) begin
      res_tx_line = tx_shift_next[0];
      res_tx_busy = 1'b1;
      if (CW'(tx_tick_count_next) + CW'(1) >= per) begin
        tx_tick_count_next = '0;
        tx_shift_next      = {1'b1, tx_shift_next[FRAME_BITS-1:1]};
        tx_bits_left_next  = tx_bits_left_next - IDX_W'(1);
      end else begin
        tx_tick_count_next = tx_tick_count_next + TICK_COUNT_WIDTH'(1);
      end
    end
  end

  // Receiver. The first wait is half a bit so that every sample lands at
  // mid-bit; a one-tick period samples the start bit on the edge itself.
  always_comb begin
    rx_active_next     = rx_active;
    rx_shift_next      = rx_shift;
    rx_bit_index_next  = rx_bit_index;
    rx_tick_count_next = rx_tick_count;
    res_rx_valid       = 1'b0;
    res_rx_byte        = '0;
    rx_ext             = '0;
    if (!rx_active && !item_in.rx_line) begin
      rx_active_next     = 1'b1;
      rx_shift_next      = '0;
      rx_bit_index_next  = '0;
      rx_tick_count_next = TICK_COUNT_WIDTH'(per >> 1);
    end
    if (rx_active_next) begin
      if (rx_tick_count_next == '0) begin
        rx_shift_next      = rx_shift_next |
                             (FRAME_BITS'(item_in.rx_line) << rx_bit_index_next);
        rx_bit_index_next  = rx_bit_index_next + IDX_W'(1);
        rx_tick_count_next = TICK_COUNT_WIDTH'(per - CW'(1));
        if (rx_bit_index_next >= IDX_W'(FRAME_BITS)) begin
          rx_active_next = 1'b0;
          if (!rx_shift_next[0] && rx_shift_next[FRAME_BITS-1]) begin
            rx_ext       = EXT_W'(rx_shift_next[FRAME_BITS-2:1]);
            res_rx_valid = 1'b1;
            res_rx_byte  = rx_ext[BYTE_W-1:0];
          end
        end
      end else begin
        rx_tick_count_next = rx_tick_count_next - TICK_COUNT_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_period <= BIT_PERIOD_RESET;
    end else if (cfg_we) begin
      bit_period <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_shift      <= '1;
      tx_bits_left  <= '0;
      tx_tick_count <= '0;
      rx_active     <= 1'b0;
      rx_shift      <= '0;
      rx_bit_index  <= '0;
      rx_tick_count <= '0;
    end else if (accept) begin
      tx_shift      <= tx_shift_next;
      tx_bits_left  <= tx_bits_left_next;
      tx_tick_count <= tx_tick_count_next;
      rx_active     <= rx_active_next;
      rx_shift      <= rx_shift_next;
      rx_bit_index  <= rx_bit_index_next;
      rx_tick_count <= rx_tick_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tx_line     <= res_tx_line;
      tx_busy     <= res_tx_busy;
      tx_accepted <= res_tx_accepted;
      rx_valid    <= res_rx_valid;
      rx_byte     <= res_rx_byte;
    end
  end

  assign result_out.valid       = out_valid;
  assign result_out.tx_line     = tx_line;
  assign result_out.tx_busy     = tx_busy;
  assign result_out.tx_accepted = tx_accepted;
  assign result_out.rx_valid    = rx_valid;
  assign result_out.rx_byte     = rx_byte;

`ifndef SYNTH
  // A stalled result must hold off the next tick request.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result_out.ready |-> !item_in.ready)
    else $error("tick request taken while a result is stalled");

  // A byte taken for transmission starts its frame with the start bit.
  a_accept_starts_frame: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && tx_accepted |-> tx_busy && !tx_line)
    else $error("accepted byte did not start a frame");

  // The transmit and receive bit counters stay within one frame.
  a_counters_in_frame: assert property (@(posedge clk) disable iff (rst)
    accept |=> tx_bits_left <= IDX_W'(FRAME_BITS) && rx_bit_index <= IDX_W'(FRAME_BITS))
    else $error("bit counter ran past the frame");

  // A dropped or absent frame reports a zero byte.
  a_byte_zero_when_invalid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !rx_valid |-> rx_byte == '0)
    else $error("received byte set without a valid frame");
`endif

endmodule

>>> bench/uart_trx_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UART transceiver result checker
// Keeps its own copy of the transmit and receive state, advances it by one
// tick for every accepted tick request, and compares each result taken from
// the transceiver, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module uart_trx_checker
  import uart_trx_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [BIT_PERIOD_W-1:0] cfg_wdata,
  uart_trx_in_if                  tick_ch,
  uart_trx_out_if                 res_ch,
  output int                      errors,
  output int                      pending,
  output int                      tx_frames,
  output int                      rx_frames
);

  localparam int FRAME_LEN   = FRAME_BITS_DEFAULT;
  localparam int CNT_W       = TICK_COUNT_WIDTH_DEFAULT;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic  tx_line;
    logic  tx_busy;
    logic  tx_accepted;
    logic  rx_valid;
    byte_t rx_byte;
  } tick_result_t;

  logic [BIT_PERIOD_W-1:0] bit_period;
  logic [FRAME_LEN-1:0]    tx_shift;
  logic [3:0]              tx_bits_left;
  logic [CNT_W-1:0]        tx_ticks;
  logic                    rx_active;
  logic [FRAME_LEN-1:0]    rx_shift;
  logic [3:0]              rx_index;
  logic [CNT_W-1:0]        rx_countdown;
  tick_result_t            line_results[$];

  // One tick of both directions. A zero period runs as one tick per bit.
  function automatic tick_result_t advance_tick(logic line, logic req, byte_t data);
    tick_result_t r;
    logic [CNT_W:0] per;
    per = (bit_period == '0) ? (CNT_W+1)'(1) : (CNT_W+1)'(bit_period);
    r = '0;
    r.tx_line = 1'b1;

    if (tx_bits_left == 4'd0 && req) begin
      tx_shift     = {1'b1, data, 1'b0};
      tx_bits_left = 4'(FRAME_LEN);
      tx_ticks     = '0;
      r.tx_accepted = 1'b1;
    end
    if (tx_bits_left != 4'd0) begin
      r.tx_line = tx_shift[0];
      r.tx_busy = 1'b1;
      if ({1'b0, tx_ticks} + 1'b1 >= per) begin
        tx_ticks     = '0;
        tx_shift     = {1'b1, tx_shift[FRAME_LEN-1:1]};
        tx_bits_left = tx_bits_left - 4'd1;
      end else begin
        tx_ticks = tx_ticks + 1'b1;
      end
    end

    // A low level on an idle receiver starts a frame; samples fall at mid-bit.
    if (!rx_active && !line) begin
      rx_active    = 1'b1;
      rx_shift     = '0;
      rx_index     = '0;
      rx_countdown = per[CNT_W:1];
    end
    if (rx_active) begin
      if (rx_countdown == '0) begin
        if (rx_index < FRAME_LEN) rx_shift[rx_index] = rx_shift[rx_index] | line;
        rx_index     = rx_index + 4'd1;
        rx_countdown = CNT_W'(per - 1'b1);
        if (rx_index >= FRAME_LEN) begin
          rx_active = 1'b0;
          if (!rx_shift[0] && rx_shift[FRAME_LEN-1]) begin
            r.rx_valid = 1'b1;
            r.rx_byte  = rx_shift[FRAME_LEN-2:1];
          end
        end
      end else begin
        rx_countdown = rx_countdown - 1'b1;
      end
    end
    return r;
  endfunction

  task automatic note_error(string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("%0t: %s", $time, msg);
  endtask

  task automatic check_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want)
      note_error($sformatf("%s mismatch: expected %0h, got %0h", field, want, got));
  endtask

  always @(posedge clk) begin
    tick_result_t want;
    if (rst) begin
      bit_period   = BIT_PERIOD_RESET;
      tx_shift     = '1;
      tx_bits_left = '0;
      tx_ticks     = '0;
      rx_active    = 1'b0;
      rx_shift     = '0;
      rx_index     = '0;
      rx_countdown = '0;
      line_results.delete();
      errors       = 0;
      tx_frames    = 0;
      rx_frames    = 0;
    end else begin
      // Results leave before the new request is predicted, so a result that
      // shows up with nothing outstanding is caught.
      if (res_ch.valid && res_ch.ready) begin
        if (line_results.size() == 0) begin
          note_error("result with no tick request outstanding");
        end else begin
          want = line_results.pop_front();
          check_field("tx_line", want.tx_line, res_ch.tx_line);
          check_field("tx_busy", want.tx_busy, res_ch.tx_busy);
          check_field("tx_accepted", want.tx_accepted, res_ch.tx_accepted);
          check_field("rx_valid", want.rx_valid, res_ch.rx_valid);
          check_field("rx_byte", want.rx_byte, res_ch.rx_byte);
        end
      end
      if (tick_ch.valid && tick_ch.ready) begin
        want = advance_tick(tick_ch.rx_line, tick_ch.tx_request, tick_ch.tx_byte);
        line_results.push_back(want);
        if (want.tx_accepted) tx_frames++;
        if (want.rx_valid) rx_frames++;
      end
      // A period written at this edge applies from the next tick onward.
      if (cfg_we) bit_period = cfg_wdata;
    end
    pending = line_results.size();
  end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UART 8N1 transceiver testbench
// Drives tick requests carrying serial frames on the receive line and random
// transmit offers, under several bit periods, with random stalls on both
// channels; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
  import uart_trx_pkg::*;

  localparam int FRAME_LEN       = FRAME_BITS_DEFAULT;
  localparam int HOLD_OFF_CYCLES = 64;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam logic [BIT_PERIOD_W-1:0] PERIOD_MAX = '1;

  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    cfg_we    = 1'b0;
  logic [BIT_PERIOD_W-1:0] cfg_wdata = '0;

  uart_trx_in_if  tick_ch();
  uart_trx_out_if res_ch();

  int errors;
  int pending;
  int tx_frames;
  int rx_frames;
  int ticks_sent     = 0;
  int settings_used  = 0;
  int idle_cycles    = 0;
  bit line_plan[$];
  bit hold_off_req   = 1'b0;
  bit source_steady  = 1'b0;
  bit sink_steady    = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  uart_8n1_tx_rx u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .item_in    (tick_ch),
    .result_out (res_ch)
  );

  uart_trx_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .tick_ch   (tick_ch),
    .res_ch    (res_ch),
    .errors    (errors),
    .pending   (pending),
    .tx_frames (tx_frames),
    .rx_frames (rx_frames)
  );

  // Mostly no gap, sometimes a few cycles, rarely a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  task automatic send_tick(bit line, bit req, byte_t data);
    int gap;
    gap = source_steady ? 0 : pick_gap();
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    tick_ch.valid      <= 1'b1;
    tick_ch.rx_line    <= line;
    tick_ch.tx_request <= req;
    tick_ch.tx_byte    <= data;
    do @(posedge clk); while (!tick_ch.ready);
    @(negedge clk);
    ticks_sent++;
  endtask

  task automatic push_frame(byte_t data, bit stop, int per);
    logic [FRAME_LEN-1:0] bits;
    bits = {stop, data, 1'b0};
    for (int b = 0; b < FRAME_LEN; b++)
      repeat (per) line_plan.push_back(bits[b]);
  endtask

  // Mostly clean frames, some with a low stop bit, some plain line noise.
  task automatic refill_plan(int per);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) push_frame(byte_t'($urandom), 1'b1, per);
    else if (r < 85) push_frame(byte_t'($urandom), 1'b0, per);
    else repeat ($urandom_range(1, 3 * per)) line_plan.push_back($urandom_range(0, 1));
    repeat ($urandom_range(0, 2 * per)) line_plan.push_back(1'b1);
  endtask

  task automatic drain();
    tick_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_period(logic [BIT_PERIOD_W-1:0] p);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= p;
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic run_phase(logic [BIT_PERIOD_W-1:0] p, int n, bit quiet, bit pause_midway,
                           bit hold_off, bit settle);
    int per;
    bit line;
    write_period(p);
    per = (p == '0) ? 1 : int'(p);
    line_plan.delete();
    if (hold_off) hold_off_req = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (pause_midway && i == n / 2) drain();
      if (!quiet && line_plan.size() == 0) refill_plan(per);
      line = quiet ? 1'b1 : line_plan.pop_front();
      send_tick(line, $urandom_range(0, 3) == 0, byte_t'($urandom));
    end
    // A high line for a whole frame lets the receiver finish and go idle.
    if (settle) repeat ((FRAME_LEN + 2) * per) send_tick(1'b1, 1'b0, byte_t'($urandom));
  endtask

  // Result side: random stalls, plus one long hold-off on demand.
  initial begin
    int stall;
    res_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        stall = sink_steady ? 0 : pick_gap();
        if (stall > 0) begin
          res_ch.ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
        res_ch.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("Watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int k;
    tick_ch.valid      = 1'b0;
    tick_ch.rx_line    = 1'b1;
    tick_ch.tx_request = 1'b0;
    tick_ch.tx_byte    = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // At the reset period: one byte taken, then offers refused while busy.
    send_tick(1'b1, 1'b1, 8'hFF);
    send_tick(1'b1, 1'b1, 8'h00);
    send_tick(1'b1, 1'b1, 8'h55);
    send_tick(1'b1, 1'b1, 8'hAA);

    // One tick per bit, changed while the frame above is still going out:
    // a clean all-zero byte, then all ones with a low stop bit.
    write_period(16'd1);
    push_frame(8'h00, 1'b1, 1);
    push_frame(8'hFF, 1'b0, 1);
    line_plan.push_back(1'b1);
    k = 0;
    while (line_plan.size() != 0) begin
      send_tick(line_plan.pop_front(), k % 3 == 0, k[0] ? 8'hFF : 8'h00);
      k++;
    end

    run_phase(16'd1, 250, 1'b0, 1'b0, 1'b0, 1'b0);
    source_steady = 1'b1;
    sink_steady   = 1'b1;
    run_phase(16'd0, 200, 1'b0, 1'b0, 1'b0, 1'b0);
    source_steady = 1'b0;
    sink_steady   = 1'b0;
    run_phase(16'd2, 200, 1'b0, 1'b0, 1'b0, 1'b0);
    run_phase(16'd3, 200, 1'b0, 1'b0, 1'b1, 1'b1);
    // The longest period is far too slow to finish a frame in this phase; the
    // receive line is held idle and only the first transmit bit is seen.
    run_phase(PERIOD_MAX, 60, 1'b1, 1'b0, 1'b0, 1'b0);
    run_phase(16'd5, 250, 1'b0, 1'b1, 1'b0, 1'b0);
    run_phase(16'd7, 250, 1'b0, 1'b0, 1'b0, 1'b0);
    run_phase(16'd16, 300, 1'b0, 1'b0, 1'b0, 1'b0);

    drain();
    repeat (4) @(posedge clk);
    $display("Ran %0d line ticks under %0d bit period settings, from 0 up to %0d.",
             ticks_sent, settings_used, PERIOD_MAX);
    $display("Transmitter took %0d bytes; receiver delivered %0d well-framed bytes.",
             tx_frames, rx_frames);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/uart_trx_pkg.sv
hw/rtl/uart_trx_if.sv
hw/rtl/uart_8n1_tx_rx.sv
bench/uart_trx_checker.sv
bench/tb_top.sv
